### rtl/core/ctgu_pkg.sv
// Shared constants, command codes and request/response/job types of the tableau update unit.
`timescale 1ns / 1ps

package ctgu_pkg;

  localparam int MAX_QUBITS     = 32;
  localparam int MAX_GATE_WIRES = 3;
  localparam int ROWS           = 2 * MAX_QUBITS;
  localparam int QW             = $clog2(MAX_QUBITS);
  localparam int RAW            = $clog2(ROWS);
  localparam int ROW_W          = 2 * MAX_QUBITS + 2;
  localparam int CNT_W          = 6;
  localparam int IMG_W          = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [CNT_W-1:0] QUBIT_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    CMD_APPLY = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_APPLY = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] gate_width;
    logic [5:0] wire_0;
    logic [5:0] wire_1;
    logic [5:0] wire_2;
    logic [7:0] x_image_0;
    logic [7:0] x_image_1;
    logic [7:0] x_image_2;
    logic [7:0] z_image_0;
    logic [7:0] z_image_1;
    logic [7:0] z_image_2;
    logic [5:0] row_index;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] row_x;
    logic [31:0] row_z;
    logic [1:0]  row_phase;
  } rsp_t;

  // Classified request as it waits in the queue
  typedef struct packed {
    op_t                                  op;
    logic                                 status;
    logic [1:0]                           width;
    logic [MAX_GATE_WIRES-1:0][QW-1:0]    wire_idx;
    logic [MAX_GATE_WIRES-1:0][IMG_W-1:0] ix;
    logic [MAX_GATE_WIRES-1:0][IMG_W-1:0] iz;
    logic [MAX_GATE_WIRES-1:0][1:0]       ip;
    logic [MAX_GATE_WIRES-1:0][IMG_W-1:0] jx;
    logic [MAX_GATE_WIRES-1:0][IMG_W-1:0] jz;
    logic [MAX_GATE_WIRES-1:0][1:0]       jp;
    logic [RAW-1:0]                       row;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/ctgu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ctgu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ctgu_fifo.sv
// Short request queue between the classifying front and the row engine.
`timescale 1ns / 1ps

module ctgu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ctgu_pkg::job_t    push_job,
  input  logic              pop,
  output ctgu_pkg::job_t    head,
  output ctgu_pkg::q_stat_t stat
);

  import ctgu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign do_push = push && (cnt_r != CW'(DEPTH));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  assign head       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### rtl/core/ctgu_front.sv
// Front end: checks a request against the qubit count and turns it into a queue job.
`timescale 1ns / 1ps

module ctgu_front (
  input  ctgu_pkg::req_t             req,
  input  logic [ctgu_pkg::CNT_W-1:0] n_eff,
  input  logic [ctgu_pkg::CNT_W:0]   n_rows,
  output ctgu_pkg::job_t             job
);

  import ctgu_pkg::*;

  logic [MAX_GATE_WIRES-1:0][5:0] wires;
  logic [MAX_GATE_WIRES-1:0][7:0] ximg;
  logic [MAX_GATE_WIRES-1:0][7:0] zimg;
  logic [IMG_W-1:0]               mask;
  logic                           bad_wire;

  assign wires = {req.wire_2, req.wire_1, req.wire_0};
  assign ximg  = {req.x_image_2, req.x_image_1, req.x_image_0};
  assign zimg  = {req.z_image_2, req.z_image_1, req.z_image_0};

  always_comb begin
    job      = '0;
    mask     = '0;
    bad_wire = 1'b0;
    for (int k = 0; k < IMG_W; k++) begin
      mask[k] = (k < int'(req.gate_width));
    end
    for (int j = 0; j < MAX_GATE_WIRES; j++) begin
      if ((j < int'(req.gate_width)) && (wires[j] >= n_eff)) begin
        bad_wire = 1'b1;
      end
      job.wire_idx[j] = wires[j][QW-1:0];
      job.ix[j]       = ximg[j][2:0] & mask;
      job.iz[j]       = ximg[j][5:3] & mask;
      job.ip[j]       = ximg[j][7:6];
      job.jx[j]       = zimg[j][2:0] & mask;
      job.jz[j]       = zimg[j][5:3] & mask;
      job.jp[j]       = zimg[j][7:6];
    end
    job.width = req.gate_width;
    job.row   = req.row_index[RAW-1:0];
    job.op    = OP_NONE;

    case (cmd_t'(req.cmd))
      CMD_APPLY: begin
        if (req.gate_width == 2'd0) begin
          job.status = 1'b0;
        end else if ((int'(req.gate_width) > MAX_GATE_WIRES) || bad_wire) begin
          job.status = 1'b1;
        end else begin
          job.op = OP_APPLY;
        end
      end
      CMD_READ: begin
        if ({1'b0, req.row_index} < n_rows) begin
          job.op = OP_READ;
        end else begin
          job.status = 1'b1;
        end
      end
      CMD_CLEAR: begin
        job.op = OP_CLEAR;
      end
      default: begin
        job.status = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/ctgu_back.sv
// Back end: sweeps the row memory for gates, serves row reads and restores the identity.
`timescale 1ns / 1ps

module ctgu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ctgu_pkg::CNT_W-1:0] n_eff,
  input  logic [ctgu_pkg::CNT_W:0]   n_rows,
  input  ctgu_pkg::q_stat_t          q_stat,
  input  ctgu_pkg::job_t             q_head,
  output logic                       q_pop,
  output logic                       out_strobe,
  output ctgu_pkg::rsp_t             out_rsp
);

  import ctgu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [RAW-1:0]   row_r, row_nxt;
  logic             hit_r, hit_nxt;
  logic [ROWS-1:0]  valid_r, valid_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;

  logic             ram_we, ram_re;
  logic [RAW-1:0]   ram_raddr;
  logic [ROW_W-1:0] ram_rdata, cur_row, new_row;
  logic             last_row;

  // Row as left by the last clear: X on its own qubit, then Z
  function automatic logic [ROW_W-1:0] ident_row(input logic [RAW-1:0] r,
                                                 input logic [CNT_W-1:0] n,
                                                 input logic [CNT_W:0] n2);
    logic [MAX_QUBITS-1:0] x, z;
    logic [CNT_W:0]        rr, d;
    x  = '0;
    z  = '0;
    rr = (CNT_W + 1)'(r);
    d  = rr - {1'b0, n};
    if (rr < {1'b0, n}) begin
      x[rr[QW-1:0]] = 1'b1;
    end else if (rr < n2) begin
      z[d[QW-1:0]] = 1'b1;
    end
    return {2'b00, z, x};
  endfunction

  // Multiply the wire images picked by the row's X and Z bits, then write back
  function automatic logic [ROW_W-1:0] row_update(input logic [ROW_W-1:0] row,
                                                  input job_t jb);
    logic [MAX_QUBITS-1:0] x, z, xo, zo;
    logic [1:0]            ph, ap;
    logic [IMG_W-1:0]      ax, az;
    x  = row[MAX_QUBITS-1:0];
    z  = row[2*MAX_QUBITS-1:MAX_QUBITS];
    ph = row[ROW_W-1 -: 2];
    ax = '0;
    az = '0;
    ap = '0;
    for (int j = 0; j < MAX_GATE_WIRES; j++) begin
      if (j < int'(jb.width)) begin
        if (x[jb.wire_idx[j]]) begin
          ap = ap + jb.ip[j] + {^(az & jb.ix[j]), 1'b0};
          ax = ax ^ jb.ix[j];
          az = az ^ jb.iz[j];
        end
        if (z[jb.wire_idx[j]]) begin
          ap = ap + jb.jp[j] + {^(az & jb.jx[j]), 1'b0};
          ax = ax ^ jb.jx[j];
          az = az ^ jb.jz[j];
        end
      end
    end
    xo = x;
    zo = z;
    // later wire positions win on duplicates
    for (int j = 0; j < MAX_GATE_WIRES; j++) begin
      if (j < int'(jb.width)) begin
        xo[jb.wire_idx[j]] = ax[j];
        zo[jb.wire_idx[j]] = az[j];
      end
    end
    return {ph + ap, zo, xo};
  endfunction

  assign cur_row  = hit_r ? ram_rdata : ident_row(row_r, n_eff, n_rows);
  assign new_row  = row_update(cur_row, job_r);
  assign last_row = (((CNT_W + 1)'(row_r)) + 1'b1) == n_rows;

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    row_nxt        = row_r;
    hit_nxt        = hit_r;
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = '0;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          case (q_head.op)
            OP_APPLY: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              row_nxt   = '0;
              hit_nxt   = valid_r[0];
              state_nxt = S_SWEEP;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = q_head.row;
              row_nxt   = q_head.row;
              hit_nxt   = valid_r[q_head.row];
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              valid_nxt      = '0;
              out_strobe_nxt = 1'b1;
            end
            default: begin
              out_strobe_nxt     = 1'b1;
              out_rsp_nxt.status = q_head.status;
            end
          endcase
        end
      end
      S_SWEEP: begin
        ram_we         = 1'b1;
        valid_nxt[row_r] = 1'b1;
        if (last_row) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // fetch the next row while this one is written back
          ram_re    = 1'b1;
          ram_raddr = row_r + 1'b1;
          row_nxt   = row_r + 1'b1;
          hit_nxt   = valid_r[row_r + 1'b1];
        end
      end
      S_READ: begin
        out_strobe_nxt        = 1'b1;
        out_rsp_nxt.row_x     = cur_row[MAX_QUBITS-1:0];
        out_rsp_nxt.row_z     = cur_row[2*MAX_QUBITS-1:MAX_QUBITS];
        out_rsp_nxt.row_phase = cur_row[ROW_W-1 -: 2];
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new qubit count brings back the identity
    if (cfg_we) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    row_r     <= row_nxt;
    hit_r     <= hit_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  ctgu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_r),
    .wdata (new_row),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

### rtl/core/clifford_tableau_gate_update_unit.sv
// Top level of the Clifford tableau update unit: config register, front end, queue, row engine.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy rises only when the two-entry
// request queue is full, so requests can be handed in while the row engine is still working.
// Every request gives exactly one response, shown on out_rsp for a single cycle with
// out_strobe high; the receiver cannot stall it and must take it then. Responses come in
// request order. A gate rewrites all 2n rows (n = effective qubit count) at one row per cycle
// through the single read and write port of the row memory, fetching the next row while the
// current one is written back. The response is registered in the row engine. Clearing and
// writing qubit count are done by dropping per-row valid bits, with no memory sweep;
// cfg_we may only be raised while no request is outstanding.
module clifford_tableau_gate_update_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ctgu_pkg::req_t             in_req,
  output logic                       out_strobe,
  output ctgu_pkg::rsp_t             out_rsp,
  input  logic                       cfg_we,
  input  logic [ctgu_pkg::CNT_W-1:0] cfg_wdata
);

  import ctgu_pkg::*;

  logic [CNT_W-1:0] qubit_count_r, qubit_count_nxt;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W:0]   n_rows;
  job_t             front_job, q_head;
  q_stat_t          q_stat;
  logic             q_pop, in_acc;

  assign qubit_count_nxt = cfg_we ? cfg_wdata : qubit_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubit_count_r <= QUBIT_COUNT_RST;
    end else begin
      qubit_count_r <= qubit_count_nxt;
    end
  end

  // counts past the tableau size act as the full size
  assign n_eff  = (int'(qubit_count_r) > MAX_QUBITS) ? CNT_W'(MAX_QUBITS) : qubit_count_r;
  assign n_rows = {n_eff, 1'b0};

  assign busy   = q_stat.full;
  assign in_acc = start && !busy;

  ctgu_front u_front (
    .req    (in_req),
    .n_eff  (n_eff),
    .n_rows (n_rows),
    .job    (front_job)
  );

  ctgu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc),
    .push_job (front_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  ctgu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .n_eff      (n_eff),
    .n_rows     (n_rows),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the Clifford tableau update unit: directed gates, count edges, random traffic.
`timescale 1ns / 1ps

module tb_top;
  import ctgu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * MAX_QUBITS + 8;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  req_t                 in_req;
  logic                 out_strobe;
  rsp_t                 out_rsp;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_wdata;

  // Predicted tableau and register copy
  logic [31:0]          tab_x  [ROWS];
  logic [31:0]          tab_z  [ROWS];
  logic [1:0]           tab_ph [ROWS];
  logic [CNT_W-1:0]     qcount;

  rsp_t                 awaited_rsp_q[$];

  int                   fail_count;
  int                   n_requests;
  int                   n_responses;
  int                   n_reads_ok;
  int                   n_rejected;
  int                   n_settings;
  int                   burst_left;

  clifford_tableau_gate_update_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int active_qubits();
    return (qcount > MAX_QUBITS) ? MAX_QUBITS : int'(qcount);
  endfunction

  function automatic void load_identity();
    int n;
    n = active_qubits();
    for (int r = 0; r < ROWS; r++) begin
      tab_x[r]  = '0;
      tab_z[r]  = '0;
      tab_ph[r] = '0;
      if (r < n) tab_x[r][r] = 1'b1;
      else if (r < 2 * n) tab_z[r][r - n] = 1'b1;
    end
  endfunction

  // Work out the response of one request and update the tableau copy
  function automatic rsp_t predict_tableau(req_t rq);
    rsp_t             res;
    int               n;
    int               w;
    int               q;
    logic [2:0]       mask;
    logic [2:0][5:0]  wire_q;
    logic [2:0][7:0]  ximg;
    logic [2:0][7:0]  zimg;
    logic [2:0][2:0]  ix, iz, jx, jz;
    logic [2:0][1:0]  ip, jp;
    logic [2:0]       ax, az;
    logic [1:0]       ap;
    bit               bad;
    res = '0;
    n   = active_qubits();
    case (rq.cmd)
      CMD_APPLY: begin
        w = int'(rq.gate_width);
        if (w != 0) begin
          mask   = 3'((1 << w) - 1);
          wire_q = {rq.wire_2, rq.wire_1, rq.wire_0};
          ximg   = {rq.x_image_2, rq.x_image_1, rq.x_image_0};
          zimg   = {rq.z_image_2, rq.z_image_1, rq.z_image_0};
          for (int j = 0; j < 3; j++) begin
            ix[j] = ximg[j][2:0] & mask;
            iz[j] = ximg[j][5:3] & mask;
            ip[j] = ximg[j][7:6];
            jx[j] = zimg[j][2:0] & mask;
            jz[j] = zimg[j][5:3] & mask;
            jp[j] = zimg[j][7:6];
          end
          bad = 1'b0;
          for (int j = 0; j < w; j++)
            if (int'(wire_q[j]) >= n) bad = 1'b1;
          if (bad) begin
            res.status = 1'b1;
          end else begin
            for (int r = 0; r < 2 * n; r++) begin
              ax = '0;
              az = '0;
              ap = '0;
              for (int j = 0; j < w; j++) begin
                q = int'(wire_q[j]);
                // 2*popcount mod 4 reduces to twice the parity
                if (tab_x[r][q]) begin
                  ap = ap + ip[j] + ((^(az & ix[j])) ? 2'd2 : 2'd0);
                  ax ^= ix[j];
                  az ^= iz[j];
                end
                if (tab_z[r][q]) begin
                  ap = ap + jp[j] + ((^(az & jx[j])) ? 2'd2 : 2'd0);
                  ax ^= jx[j];
                  az ^= jz[j];
                end
              end
              // later wire position wins on duplicates
              for (int j = 0; j < w; j++) begin
                tab_x[r][wire_q[j]] = ax[j];
                tab_z[r][wire_q[j]] = az[j];
              end
              tab_ph[r] = tab_ph[r] + ap;
            end
          end
        end
      end
      CMD_READ: begin
        if (int'(rq.row_index) < 2 * n) begin
          res.row_x     = tab_x[rq.row_index];
          res.row_z     = tab_z[rq.row_index];
          res.row_phase = tab_ph[rq.row_index];
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_CLEAR: load_identity();
      default: ;
    endcase
    return res;
  endfunction

  // Compare each response against the oldest prediction
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (rst_n && out_strobe) begin
      n_responses++;
      if (awaited_rsp_q.size() == 0) begin
        $error("response with no request outstanding: %h", out_rsp);
        fail_count++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.row_x !== want.row_x) begin
          $error("row_x: expected %h, actual %h", want.row_x, out_rsp.row_x);
          fail_count++;
        end
        if (out_rsp.row_z !== want.row_z) begin
          $error("row_z: expected %h, actual %h", want.row_z, out_rsp.row_z);
          fail_count++;
        end
        if (out_rsp.row_phase !== want.row_phase) begin
          $error("row_phase: expected %0d, actual %0d", want.row_phase, out_rsp.row_phase);
          fail_count++;
        end
      end
    end
  end

  // End the run if neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) burst_left = $urandom_range(10, 40);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic req_t mk_gate(int width, logic [5:0] w0, logic [5:0] w1, logic [5:0] w2,
                                   logic [7:0] x0, logic [7:0] z0, logic [7:0] x1,
                                   logic [7:0] z1, logic [7:0] x2, logic [7:0] z2);
    req_t rq;
    rq            = '0;
    rq.cmd        = CMD_APPLY;
    rq.gate_width = 2'(width);
    rq.wire_0     = w0;
    rq.wire_1     = w1;
    rq.wire_2     = w2;
    rq.x_image_0  = x0;
    rq.x_image_1  = x1;
    rq.x_image_2  = x2;
    rq.z_image_0  = z0;
    rq.z_image_1  = z1;
    rq.z_image_2  = z2;
    return rq;
  endfunction

  function automatic req_t mk_cmd(cmd_t c, logic [5:0] row);
    req_t rq;
    rq           = '0;
    rq.cmd       = c;
    rq.row_index = row;
    return rq;
  endfunction

  // Mostly well-formed gates and reads in range, with some rejects and noise
  function automatic req_t make_request(int n);
    req_t rq;
    int   kind;
    int   slot;
    rq.gate_width = 2'($urandom_range(0, 3));
    rq.wire_0     = 6'($urandom_range(0, 63));
    rq.wire_1     = 6'($urandom_range(0, 63));
    rq.wire_2     = 6'($urandom_range(0, 63));
    rq.x_image_0  = 8'($urandom);
    rq.x_image_1  = 8'($urandom);
    rq.x_image_2  = 8'($urandom);
    rq.z_image_0  = 8'($urandom);
    rq.z_image_1  = 8'($urandom);
    rq.z_image_2  = 8'($urandom);
    rq.row_index  = 6'($urandom_range(0, 63));
    kind          = $urandom_range(0, 99);
    if (kind < 60) begin
      rq.cmd = CMD_APPLY;
      if (kind < 55 && n > 0) begin
        rq.gate_width = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        rq.wire_0     = 6'($urandom_range(0, n - 1));
        rq.wire_1     = 6'($urandom_range(0, n - 1));
        rq.wire_2     = 6'($urandom_range(0, n - 1));
      end else begin
        rq.gate_width = 2'($urandom_range(1, 3));
        slot          = $urandom_range(0, int'(rq.gate_width) - 1);
        case (slot)
          0:       rq.wire_0 = 6'($urandom_range(n, 63));
          1:       rq.wire_1 = 6'($urandom_range(n, 63));
          default: rq.wire_2 = 6'($urandom_range(n, 63));
        endcase
      end
    end else if (kind < 92) begin
      rq.cmd = CMD_READ;
      if (n > 0 && $urandom_range(0, 9) != 0) rq.row_index = 6'($urandom_range(0, 2 * n - 1));
    end else if (kind < 96) begin
      rq.cmd = CMD_CLEAR;
    end else begin
      rq.cmd = CMD_NOP;
    end
    return rq;
  endfunction

  task automatic send_request(input req_t rq, input int gap);
    rsp_t want;
    @(negedge clk);
    in_req = rq;
    start  = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_tableau(rq);
    awaited_rsp_q = {awaited_rsp_q, want};
    n_requests++;
    if (want.status) n_rejected++;
    else if (rq.cmd == CMD_READ) n_reads_ok++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding request has answered
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_qubit_count(input logic [CNT_W-1:0] value);
    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    qcount = value;
    load_identity();
    n_settings++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_identity();
    send_request(mk_cmd(CMD_READ, 6'd0), 0);
    send_request(mk_cmd(CMD_READ, 6'd31), 1);
    send_request(mk_cmd(CMD_READ, 6'd32), 0);
    send_request(mk_cmd(CMD_READ, 6'd63), 2);
  endtask

  task automatic test_named_gates();
    // Hadamard, phase and controlled-not in their usual image form
    send_request(mk_gate(1, 6'd0, 6'd0, 6'd0, 8'h08, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    send_request(mk_cmd(CMD_READ, 6'd32), 0);
    send_request(mk_gate(1, 6'd5, 6'd0, 6'd0, 8'h49, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00), 1);
    send_request(mk_cmd(CMD_READ, 6'd5), 0);
    send_request(mk_gate(2, 6'd1, 6'd2, 6'd0, 8'h03, 8'h08, 8'h02, 8'h18, 8'h00, 8'h00), 0);
    send_request(mk_cmd(CMD_READ, 6'd1), 0);
    send_request(mk_cmd(CMD_READ, 6'd34), 3);
    // all-ones images, top phase, on the highest wires
    send_request(mk_gate(3, 6'd31, 6'd30, 6'd29, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0);
    send_request(mk_cmd(CMD_READ, 6'd63), 0);
    // duplicate wires: later position wins on write-back
    send_request(mk_gate(3, 6'd3, 6'd3, 6'd4, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h96, 8'h69), 0);
    send_request(mk_cmd(CMD_READ, 6'd3), 0);
    send_request(mk_gate(0, 6'd63, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0);
    send_request(mk_gate(2, 6'd0, 6'd32, 6'd0, 8'h01, 8'h08, 8'h02, 8'h10, 8'h00, 8'h00), 0);
    send_request(mk_gate(3, 6'd1, 6'd2, 6'd63, 8'h07, 8'h38, 8'h07, 8'h38, 8'h07, 8'h38), 0);
    send_request(mk_cmd(CMD_NOP, 6'd63), 0);
    send_request(mk_cmd(CMD_CLEAR, 6'd0), 0);
    send_request(mk_cmd(CMD_READ, 6'd32), 0);
  endtask

  task automatic test_count_edges();
    write_qubit_count(6'd0);
    send_request(mk_gate(1, 6'd0, 6'd0, 6'd0, 8'h08, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    send_request(mk_gate(0, 6'd0, 6'd0, 6'd0, 8'h08, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    send_request(mk_cmd(CMD_READ, 6'd0), 0);
    write_qubit_count(6'd1);
    send_request(mk_cmd(CMD_READ, 6'd1), 0);
    send_request(mk_cmd(CMD_READ, 6'd2), 0);
    send_request(mk_gate(1, 6'd1, 6'd0, 6'd0, 8'h08, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    write_qubit_count(6'd63);
    send_request(mk_cmd(CMD_READ, 6'd63), 0);
  endtask

  task automatic test_random_traffic(input logic [CNT_W-1:0] count, input int items);
    int n;
    write_qubit_count(count);
    n = active_qubits();
    for (int i = 0; i < items; i++) begin
      send_request(make_request(n), pick_gap());
      if ($urandom_range(0, 59) == 0) settle();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    fail_count  = 0;
    n_requests  = 0;
    n_responses = 0;
    n_reads_ok  = 0;
    n_rejected  = 0;
    n_settings  = 0;
    burst_left  = 0;
    qcount      = QUBIT_COUNT_RST;
    load_identity();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_identity();
    test_named_gates();
    test_count_edges();
    test_random_traffic(6'd1, 80);
    test_random_traffic(6'd2, 100);
    test_random_traffic(6'd3, 120);
    test_random_traffic(6'd5, 90);
    test_random_traffic(6'd8, 120);
    test_random_traffic(6'd17, 100);
    test_random_traffic(6'd31, 80);
    test_random_traffic(6'd32, 60);
    test_random_traffic(6'd45, 60);
    test_random_traffic(6'd0, 30);
    test_random_traffic(6'd63, 60);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d requests over %0d qubit-count settings, %0d responses checked",
             n_requests, n_settings, n_responses);
    $display("summary: %0d rows read back, %0d requests rejected, %0d mismatches",
             n_reads_ok, n_rejected, fail_count);
    if (fail_count == 0 && awaited_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ctgu_pkg.sv
rtl/core/ctgu_ram.sv
rtl/core/ctgu_fifo.sv
rtl/core/ctgu_front.sv
rtl/core/ctgu_back.sv
rtl/core/clifford_tableau_gate_update_unit.sv
tb/sv/tb_top.sv
